[hdl/yta_pkg.sv]
package yta_pkg;

   localparam int SUM_W = 19;

   typedef logic signed [SUM_W-1:0] sum_type;

   localparam logic signed [8:0] LUMA_OFFSET = 9'sd16;
   localparam sum_type COEF_Y  = 19'sd298;
   localparam sum_type COEF_RV = 19'sd409;
   localparam sum_type COEF_GU = 19'sd100;
   localparam sum_type COEF_GV = 19'sd208;
   localparam sum_type COEF_BU = 19'sd516;
   localparam sum_type ROUND_HALF = 19'sd128;
   localparam logic [7:0] ALPHA_BYTE = 8'hFF;
   localparam logic [7:0] CHAN_MAX = 8'd255;

   // offsets removed, chroma as signed
   typedef struct packed {
      logic signed [8:0] c0;
      logic signed [8:0] c1;
      logic signed [7:0] d;
      logic signed [7:0] e;
      logic              last;
   } offs_type;

   // coefficient products
   typedef struct packed {
      sum_type yc0;
      sum_type yc1;
      sum_type rv;
      sum_type gu;
      sum_type gv;
      sum_type bu;
      logic    last;
   } prod_type;

   // rounded channel sums before the shift
   typedef struct packed {
      sum_type r0;
      sum_type g0;
      sum_type b0;
      sum_type r1;
      sum_type g1;
      sum_type b1;
      logic    last;
   } chan_type;

   typedef struct packed {
      logic [31:0] pix0;
      logic [31:0] pix1;
      logic        last;
   } out_type;

   // floor shift by 8 then clamp to 0..255
   function automatic logic [7:0] sat_channel(input sum_type s);
      logic [7:0] res;
      if (s[SUM_W-1]) begin
         res = 8'd0;
      end else if (|s[SUM_W-2:16]) begin
         res = CHAN_MAX;
      end else begin
         res = s[15:8];
      end
      return res;
   endfunction

endpackage

[hdl/yuyv_to_argb_converter_unit.sv]
// yuyv to argb converter
//
// input channel req_*: one yuyv group per transfer, req_tlast marks the last
// group of a frame. output channel rsp_*: two argb pixels per transfer
// (0xAARRGGBB, alpha always 0xFF), rsp_tlast copies the input flag.
//
// four register stages: chroma/luma offsets, coefficient products, rounded
// channel sums, clamp and pack into the output register. an accepted group
// passes through the offset, product and sum registers into the output
// register, which drives rsp_tvalid. one group is taken per cycle, sustained,
// as long as the receiver keeps rsp_tready high.
//
// each stage moves on when it is empty or the stage after it moves, so
// bubbles are squeezed out while the receiver stalls; req_tready drops only
// once all four stages hold data and rsp_tready is low. nothing is lost or
// repeated under a stall.
//
// reset (synchronous, active high) empties every stage; no state is kept
// from one group to the next.
module yuyv_to_argb_converter_unit
   import yta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // luma_first [7:0], chroma_blue [15:8], luma_second [23:16], chroma_red [31:24]
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_first [31:0], pixel_second [63:32]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic     v1_ff, v2_ff, v3_ff, vo_ff;
   logic     v1_in, v2_in, v3_in, vo_in;
   logic     load1, load2, load3, load_o;
   offs_type s1_ff, s1_in;
   prod_type s2_ff, s2_in;
   chan_type s3_ff, s3_in;
   out_type  out_ff, out_in;

   assign load_o = !vo_ff || rsp_tready;
   assign load3  = !v3_ff || load_o;
   assign load2  = !v2_ff || load3;
   assign load1  = !v1_ff || load2;
   assign req_tready = load1;

   always_comb begin
      v1_in = load1  ? req_tvalid : v1_ff;
      v2_in = load2  ? v1_ff : v2_ff;
      v3_in = load3  ? v2_ff : v3_ff;
      vo_in = load_o ? v3_ff : vo_ff;
   end

   always_comb begin
      s1_in.c0   = $signed({1'b0, req_tdata[7:0]}) - LUMA_OFFSET;
      s1_in.c1   = $signed({1'b0, req_tdata[23:16]}) - LUMA_OFFSET;
      s1_in.d    = $signed({~req_tdata[15], req_tdata[14:8]});
      s1_in.e    = $signed({~req_tdata[31], req_tdata[30:24]});
      s1_in.last = req_tlast;
   end

   always_comb begin
      s2_in.yc0  = SUM_W'(s1_ff.c0) * COEF_Y;
      s2_in.yc1  = SUM_W'(s1_ff.c1) * COEF_Y;
      s2_in.rv   = SUM_W'(s1_ff.e) * COEF_RV;
      s2_in.gu   = SUM_W'(s1_ff.d) * COEF_GU;
      s2_in.gv   = SUM_W'(s1_ff.e) * COEF_GV;
      s2_in.bu   = SUM_W'(s1_ff.d) * COEF_BU;
      s2_in.last = s1_ff.last;
   end

   always_comb begin
      s3_in.r0   = s2_ff.yc0 + s2_ff.rv + ROUND_HALF;
      s3_in.g0   = s2_ff.yc0 - s2_ff.gu - s2_ff.gv + ROUND_HALF;
      s3_in.b0   = s2_ff.yc0 + s2_ff.bu + ROUND_HALF;
      s3_in.r1   = s2_ff.yc1 + s2_ff.rv + ROUND_HALF;
      s3_in.g1   = s2_ff.yc1 - s2_ff.gu - s2_ff.gv + ROUND_HALF;
      s3_in.b1   = s2_ff.yc1 + s2_ff.bu + ROUND_HALF;
      s3_in.last = s2_ff.last;
   end

   always_comb begin
      out_in.pix0 = {ALPHA_BYTE, sat_channel(s3_ff.r0), sat_channel(s3_ff.g0),
                     sat_channel(s3_ff.b0)};
      out_in.pix1 = {ALPHA_BYTE, sat_channel(s3_ff.r1), sat_channel(s3_ff.g1),
                     sat_channel(s3_ff.b1)};
      out_in.last = s3_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_ff <= s1_in;
      end
      if (load2) begin
         s2_ff <= s2_in;
      end
      if (load3) begin
         s3_ff <= s3_in;
      end
      if (load_o) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {out_ff.pix1, out_ff.pix0};
   assign rsp_tlast  = out_ff.last;

`ifndef ASSERT_OFF
   a_alpha : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:24] == ALPHA_BYTE && rsp_tdata[63:56] == ALPHA_BYTE))
      else $error("alpha byte not 0xFF on a result");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && vo_ff && !rsp_tready))
      else $error("input stalled while the pipeline has room");

   a_hold_mid : assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !load3) |=> (v2_ff && $stable(s2_ff)))
      else $error("stalled product stage lost or changed its data");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && !v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_GROUPS = 1050;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 30;

   typedef struct {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
      logic       frame_end;
      bit         drain_first;
   } yuyv_group_t;

   typedef struct {
      logic [31:0] pixel_first;
      logic [31:0] pixel_second;
      logic        frame_end;
   } argb_pair_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // luma_first [7:0], chroma_blue [15:8], luma_second [23:16], chroma_red [31:24]
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // pixel_first [31:0], pixel_second [63:32]
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;

   yuyv_group_t pending_groups[$];
   argb_pair_t  expected_pairs[$];
   yuyv_group_t group_on_bus;
   int          total_groups = 0;
   int          sent_count = 0;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;

   yuyv_to_argb_converter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] clamp_channel(input int value);
      logic [7:0] res;
      if (value < 0) begin
         res = 8'd0;
      end else if (value > 255) begin
         res = 8'd255;
      end else begin
         res = value[7:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] argb_of(input logic [7:0] y, input logic [7:0] u,
                                           input logic [7:0] v);
      int c;
      int d;
      int e;
      int r;
      int g;
      int b;
      c = int'(y) - 16;
      d = int'(u) - 128;
      e = int'(v) - 128;
      r = (298 * c + 409 * e + 128) >>> 8;
      g = (298 * c - 100 * d - 208 * e + 128) >>> 8;
      b = (298 * c + 516 * d + 128) >>> 8;
      return {8'hFF, clamp_channel(r), clamp_channel(g), clamp_channel(b)};
   endfunction

   function automatic argb_pair_t convert_group(input yuyv_group_t grp);
      argb_pair_t pair;
      pair.pixel_first  = argb_of(grp.luma_first, grp.chroma_blue, grp.chroma_red);
      pair.pixel_second = argb_of(grp.luma_second, grp.chroma_blue, grp.chroma_red);
      pair.frame_end    = grp.frame_end;
      return pair;
   endfunction

   // receiver idles most first, then sender, then neither
   function automatic int idle_percent(input bit receiver);
      int pct;
      if (sent_count < total_groups / 3) begin
         pct = receiver ? 46 : 13;
      end else if (sent_count < 2 * total_groups / 3) begin
         pct = receiver ? 13 : 46;
      end else begin
         pct = 0;
      end
      return pct;
   endfunction

   function automatic logic [7:0] pick_sample();
      logic [7:0] s;
      case ($urandom_range(0, 9))
         0: s = 8'd0;
         1: s = 8'd255;
         2: s = 8'd16;
         3: s = 8'd235;
         4: s = 8'd128;
         default: s = 8'($urandom);
      endcase
      return s;
   endfunction

   task automatic add_group(input logic [7:0] y0, input logic [7:0] u, input logic [7:0] y1,
                            input logic [7:0] v, input logic eof, input bit drain);
      yuyv_group_t grp;
      grp.luma_first  = y0;
      grp.chroma_blue = u;
      grp.luma_second = y1;
      grp.chroma_red  = v;
      grp.frame_end   = eof;
      grp.drain_first = drain;
      pending_groups.push_back(grp);
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s: expected %h, actual %h", what, want, got);
      end
   endtask

   initial begin
      add_group(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      add_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
      add_group(8'd16, 8'd128, 8'd235, 8'd128, 1'b0, 1'b0);
      add_group(8'd0, 8'd128, 8'd255, 8'd128, 1'b0, 1'b0);
      add_group(8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0);
      add_group(8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0);
      add_group(8'd81, 8'd90, 8'd145, 8'd240, 1'b0, 1'b0);
      add_group(8'd41, 8'd240, 8'd210, 8'd16, 1'b0, 1'b0);
      add_group(8'd16, 8'd0, 8'd16, 8'd0, 1'b0, 1'b1);
      add_group(8'd235, 8'd255, 8'd235, 8'd255, 1'b0, 1'b0);
      add_group(8'd16, 8'd255, 8'd16, 8'd255, 1'b0, 1'b0);
      add_group(8'd235, 8'd0, 8'd235, 8'd0, 1'b1, 1'b0);
      add_group(8'd128, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0);
      add_group(8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
      add_group(8'd255, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
      add_group(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1, 1'b0);
      add_group(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0);
      add_group(8'd15, 8'd127, 8'd17, 8'd129, 1'b0, 1'b0);
      add_group(8'd236, 8'd1, 8'd254, 8'd254, 1'b1, 1'b0);
      for (int i = 0; i < RANDOM_GROUPS; i++) begin
         add_group(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                   ($urandom_range(0, 15) == 0), (i == RANDOM_GROUPS / 2));
      end
      total_groups = pending_groups.size();
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(posedge clock) begin
      bit launch;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_pairs.push_back(convert_group(group_on_bus));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            launch = 1'b0;
            if (pending_groups.size() > 0) begin
               if (pending_groups[0].drain_first && expected_pairs.size() > 0) begin
                  launch = 1'b0;
               end else begin
                  launch = ($urandom_range(0, 99) >= idle_percent(1'b0));
               end
            end
            if (launch) begin
               group_on_bus = pending_groups.pop_front();
               req_tdata  <= {group_on_bus.chroma_red, group_on_bus.luma_second,
                              group_on_bus.chroma_blue, group_on_bus.luma_first};
               req_tlast  <= group_on_bus.frame_end;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      argb_pair_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pairs.size() == 0) begin
               note_mismatch("unexpected transfer", 32'h0, rsp_tdata[31:0]);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_tdata[31:0] !== want.pixel_first) begin
                  note_mismatch("pixel_first", want.pixel_first, rsp_tdata[31:0]);
               end
               if (rsp_tdata[63:32] !== want.pixel_second) begin
                  note_mismatch("pixel_second", want.pixel_second, rsp_tdata[63:32]);
               end
               if (rsp_tlast !== want.frame_end) begin
                  note_mismatch("frame_end", 32'(want.frame_end), 32'(rsp_tlast));
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= idle_percent(1'b1));
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      @(negedge reset);
      @(posedge clock);
      while (total_groups == 0 || pending_groups.size() > 0 || req_tvalid ||
             expected_pairs.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pairs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
